### hw/rtl/crcfd_pkg.sv
// ----------------------------------------------------------------------------
// crcfd_pkg
// Shared types, constants and the bytewise CRC32C step for the frame deframer.
// ----------------------------------------------------------------------------
package crcfd_pkg;

	// Default build parameters
	localparam int LENGTH_COUNT_BITS_DEF = 24;
	localparam int MAC_BYTES_DEF         = 32;

	// Frame layout
	localparam int HDR_CRC_BYTES = 16;
	localparam int HDR_BYTES     = 20;
	localparam int TRAILER_BYTES = 4;

	// Reflected CRC32C polynomial
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Configuration register reset values
	localparam logic [31:0] MAGIC_RST     = 32'h4943_4631;
	localparam logic [15:0] VER_MIN_RST   = 16'd1;
	localparam logic [15:0] VER_MAX_RST   = 16'd1;
	localparam logic [15:0] TYPE_MAX_RST  = 16'd26;
	localparam logic [31:0] KNOWN_RST     = 32'd1;
	localparam logic [31:0] SIGNED_RST    = 32'd1;
	localparam logic [23:0] PAY_LIMIT_RST = 24'd65536;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MAGIC      = 3'd0,
		REG_VER_MIN    = 3'd1,
		REG_VER_MAX    = 3'd2,
		REG_TYPE_MAX   = 3'd3,
		REG_KNOWN_MASK = 3'd4,
		REG_SIGNED_MASK = 3'd5,
		REG_PAY_LIMIT  = 3'd6,
		REG_SIGN_REQ   = 3'd7
	} reg_idx_t;

	// Frame status codes
	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_MAGIC       = 4'd1,
		ST_HDR_CRC     = 4'd2,
		ST_VERSION     = 4'd3,
		ST_TYPE        = 4'd4,
		ST_FLAGS       = 4'd5,
		ST_LENGTH      = 4'd6,
		ST_SIGNED_NOKEY = 4'd7,
		ST_NEED_KEY    = 4'd8,
		ST_PAYLOAD_CRC = 4'd9
	} status_t;

	// Result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// One byte through the reflected CRC32C shift register
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### hw/rtl/crc32c_frame_deframer.sv
// ----------------------------------------------------------------------------
// crc32c_frame_deframer
// Parses a length-prefixed byte stream with CRC32C-protected header and
// payload, passes payload bytes on and reports one status per header or frame.
//
//  channel   dir  handshake            fields
//  in        in   in_valid/in_ready    stream_byte
//  out       out  out_valid/out_ready  kind, data_byte, status, msg_type,
//                                      version, flag_bits, frame_length,
//                                      mac_present
//  cfg       in   cfg_wr_en            cfg_index, cfg_wdata
//
// One byte per cycle unless the output stalls: an accepted byte is held in the
// input register, is parsed there, and its result is loaded into the output
// register. The output register frees in the cycle it is taken, so the input
// side only stalls while a result is waiting.
// Any nonzero status halts the parser: bytes are still taken and dropped, and
// nothing more comes out until arst_n is asserted.
// ----------------------------------------------------------------------------
module crc32c_frame_deframer #(
	parameter int LENGTH_COUNT_BITS = crcfd_pkg::LENGTH_COUNT_BITS_DEF,
	parameter int MAC_BYTES         = crcfd_pkg::MAC_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration writes
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// Stream input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	// Results
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [3:0]  status,
	output logic [15:0] msg_type,
	output logic [15:0] version,
	output logic [31:0] flag_bits,
	output logic [23:0] frame_length,
	output logic        mac_present
);
	import crcfd_pkg::*;

	localparam int PW       = LENGTH_COUNT_BITS;
	localparam int MAC_LAST = (MAC_BYTES > 0) ? MAC_BYTES - 1 : 0;
	localparam logic [32:0] CMAX = (33'd1 << PW) - 33'd1;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_TRAILER,
		PH_MAC
	} phase_t;

	// Configuration registers
	logic [31:0] magic_q, known_mask_q, signed_mask_q;
	logic [15:0] ver_min_q, ver_max_q, type_max_q;
	logic [23:0] pay_limit_q;
	logic        sign_req_q;

	// Parser state
	phase_t      phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [31:0] crc_q, crc_d;
	logic        magic_ok_q, magic_ok_d;
	logic [15:0] hdr_ver_q, hdr_ver_d, hdr_type_q, hdr_type_d;
	logic [31:0] hdr_flags_q, hdr_flags_d, hdr_len_q, hdr_len_d;
	logic [31:0] rcv_crc_q, rcv_crc_d;
	logic        halted_q, halted_d;

	// Input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Output register
	logic        out_valid_q;
	logic        kind_q, signed_q;
	logic [7:0]  data_q;
	status_t     status_q;
	logic [15:0] type_q, ver_q;
	logic [31:0] flags_q;
	logic [23:0] len_q;

	// Parse results
	logic        proc;
	logic        res_valid, res_kind, res_signed;
	status_t     res_status, hdr_status, end_status;
	logic [7:0]  res_data;
	logic [31:0] crc_upd, rcv_shift;
	logic [PW:0] pos_inc;
	logic        is_signed;
	logic [7:0]  magic_want;

	// Parse the held byte when the output register is free or being drained
	assign proc     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || proc;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q       <= MAGIC_RST;
			ver_min_q     <= VER_MIN_RST;
			ver_max_q     <= VER_MAX_RST;
			type_max_q    <= TYPE_MAX_RST;
			known_mask_q  <= KNOWN_RST;
			signed_mask_q <= SIGNED_RST;
			pay_limit_q   <= PAY_LIMIT_RST;
			sign_req_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAGIC:       magic_q       <= cfg_wdata;
				REG_VER_MIN:     ver_min_q     <= cfg_wdata[15:0];
				REG_VER_MAX:     ver_max_q     <= cfg_wdata[15:0];
				REG_TYPE_MAX:    type_max_q    <= cfg_wdata[15:0];
				REG_KNOWN_MASK:  known_mask_q  <= cfg_wdata;
				REG_SIGNED_MASK: signed_mask_q <= cfg_wdata;
				REG_PAY_LIMIT:   pay_limit_q   <= cfg_wdata[23:0];
				REG_SIGN_REQ:    sign_req_q    <= cfg_wdata[0];
				default:         ;
			endcase
		end
	end

	// Capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= stream_byte;
		end
	end

	// Shared helpers
	assign crc_upd   = crc32c_byte(crc_q, byte_s1);
	assign rcv_shift = {rcv_crc_q[23:0], byte_s1};
	assign pos_inc   = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};
	assign is_signed = |(hdr_flags_q & signed_mask_q);

	// Expected magic byte, most significant first
	always_comb begin
		case (pos_q[1:0])
			2'd0:    magic_want = magic_q[31:24];
			2'd1:    magic_want = magic_q[23:16];
			2'd2:    magic_want = magic_q[15:8];
			default: magic_want = magic_q[7:0];
		endcase
	end

	// Header checks in priority order, on the completed header
	always_comb begin
		logic sig;
		sig = |(hdr_flags_q & signed_mask_q);
		if (!magic_ok_q)
			hdr_status = ST_MAGIC;
		else if (rcv_shift != ~crc_q)
			hdr_status = ST_HDR_CRC;
		else if (hdr_ver_q < ver_min_q || hdr_ver_q > ver_max_q)
			hdr_status = ST_VERSION;
		else if (hdr_type_q == 16'd0 || hdr_type_q > type_max_q)
			hdr_status = ST_TYPE;
		else if ((hdr_flags_q & ~known_mask_q) != 32'd0)
			hdr_status = ST_FLAGS;
		else if (hdr_len_q > {8'd0, pay_limit_q} || {1'b0, hdr_len_q} > CMAX)
			hdr_status = ST_LENGTH;
		else if (sig && !sign_req_q)
			hdr_status = ST_SIGNED_NOKEY;
		else if (!sig && sign_req_q)
			hdr_status = ST_NEED_KEY;
		else
			hdr_status = ST_OK;
	end

	// Next state and result for the held byte
	always_comb begin
		logic [31:0] rcv_fin;
		logic        at_end;
		phase_d     = phase_q;
		pos_d       = pos_q;
		crc_d       = crc_q;
		magic_ok_d  = magic_ok_q;
		hdr_ver_d   = hdr_ver_q;
		hdr_type_d  = hdr_type_q;
		hdr_flags_d = hdr_flags_q;
		hdr_len_d   = hdr_len_q;
		rcv_crc_d   = rcv_crc_q;
		halted_d    = halted_q;
		res_valid   = 1'b0;
		res_kind    = KIND_STATUS;
		res_data    = 8'd0;
		res_status  = ST_OK;
		res_signed  = is_signed;
		end_status  = ST_OK;
		rcv_fin     = rcv_crc_q;
		at_end      = 1'b0;

		if (!halted_q) begin
			unique case (phase_q)
				PH_HEADER: begin
					pos_d = pos_inc[PW-1:0];
					if (pos_q < PW'(HDR_CRC_BYTES))
						crc_d = crc_upd;
					if (pos_q < PW'(4)) begin
						if (byte_s1 != magic_want)
							magic_ok_d = 1'b0;
					end else if (pos_q < PW'(6)) begin
						hdr_ver_d = {hdr_ver_q[7:0], byte_s1};
					end else if (pos_q < PW'(8)) begin
						hdr_type_d = {hdr_type_q[7:0], byte_s1};
					end else if (pos_q < PW'(12)) begin
						hdr_flags_d = {hdr_flags_q[23:0], byte_s1};
					end else if (pos_q < PW'(HDR_CRC_BYTES)) begin
						hdr_len_d = {hdr_len_q[23:0], byte_s1};
					end else begin
						rcv_crc_d = rcv_shift;
					end
					// Last header byte: report errors or start the payload
					if (pos_q == PW'(HDR_BYTES - 1)) begin
						if (hdr_status != ST_OK) begin
							res_valid  = 1'b1;
							res_status = hdr_status;
							halted_d   = 1'b1;
						end else begin
							crc_d     = CRC_INIT;
							rcv_crc_d = 32'd0;
							pos_d     = '0;
							phase_d   = (hdr_len_q == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					crc_d     = crc_upd;
					pos_d     = pos_inc[PW-1:0];
					res_valid = 1'b1;
					res_kind  = KIND_DATA;
					res_data  = byte_s1;
					if (33'(pos_inc) >= {1'b0, hdr_len_q}) begin
						pos_d   = '0;
						phase_d = PH_TRAILER;
					end
				end
				PH_TRAILER: begin
					rcv_crc_d = rcv_shift;
					rcv_fin   = rcv_shift;
					pos_d     = pos_inc[PW-1:0];
					if (pos_q == PW'(TRAILER_BYTES - 1)) begin
						pos_d = '0;
						if (is_signed && MAC_BYTES > 0)
							phase_d = PH_MAC;
						else
							at_end = 1'b1;
					end
				end
				PH_MAC: begin
					pos_d = pos_inc[PW-1:0];
					if (pos_q == PW'(MAC_LAST)) begin
						pos_d  = '0;
						at_end = 1'b1;
					end
				end
				default: ;
			endcase

			// Frame end: check the payload CRC, restart or halt
			if (at_end) begin
				end_status = (rcv_fin == ~crc_q) ? ST_OK : ST_PAYLOAD_CRC;
				res_valid  = 1'b1;
				res_status = end_status;
				if (end_status == ST_OK) begin
					phase_d     = PH_HEADER;
					pos_d       = '0;
					crc_d       = CRC_INIT;
					magic_ok_d  = 1'b1;
					hdr_ver_d   = 16'd0;
					hdr_type_d  = 16'd0;
					hdr_flags_d = 32'd0;
					hdr_len_d   = 32'd0;
					rcv_crc_d   = 32'd0;
				end else begin
					halted_d = 1'b1;
				end
			end
		end
	end

	// Advance parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			crc_q       <= CRC_INIT;
			magic_ok_q  <= 1'b1;
			hdr_ver_q   <= 16'd0;
			hdr_type_q  <= 16'd0;
			hdr_flags_q <= 32'd0;
			hdr_len_q   <= 32'd0;
			rcv_crc_q   <= 32'd0;
			halted_q    <= 1'b0;
		end else if (proc) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			crc_q       <= crc_d;
			magic_ok_q  <= magic_ok_d;
			hdr_ver_q   <= hdr_ver_d;
			hdr_type_q  <= hdr_type_d;
			hdr_flags_q <= hdr_flags_d;
			hdr_len_q   <= hdr_len_d;
			rcv_crc_q   <= rcv_crc_d;
			halted_q    <= halted_d;
		end
	end

	// Output register: load a new result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			kind_q   <= res_kind;
			data_q   <= res_data;
			if (res_kind == KIND_STATUS) begin
				status_q <= res_status;
				type_q   <= hdr_type_q;
				ver_q    <= hdr_ver_q;
				flags_q  <= hdr_flags_q;
				len_q    <= hdr_len_q[23:0];
				signed_q <= res_signed;
			end else begin
				status_q <= ST_OK;
				type_q   <= 16'd0;
				ver_q    <= 16'd0;
				flags_q  <= 32'd0;
				len_q    <= 24'd0;
				signed_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_q;
	assign status       = status_q;
	assign msg_type     = type_q;
	assign version      = ver_q;
	assign flag_bits    = flags_q;
	assign frame_length = len_q;
	assign mac_present  = signed_q;

	// Halt is sticky until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("parser left halt without reset");

	// No result is produced once halted
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && !out_valid_q |=> !out_valid_q)
		else $error("result produced while halted");

	// Payload phase only with a nonzero length
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> hdr_len_q != 32'd0)
		else $error("payload phase with zero length");

	// Header position stays inside the header while parsing
	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER && !halted_q |-> pos_q < PW'(HDR_BYTES))
		else $error("header position out of range");

endmodule

### test/crc32c_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_frame_deframer_tb
// Self-checking bench for the frame deframer. It builds well-formed frames
// with their header and payload CRC32C, feeds them byte by byte under random
// idling and back-pressure, and predicts every payload byte and frame status
// with its own parser model. Register settings change between frames. Since
// any error halts the block until reset, one randomly chosen error frame
// closes the run, followed by bytes that must be dropped.
// ----------------------------------------------------------------------------
module crc32c_frame_deframer_tb;
	import crcfd_pkg::*;

	localparam int MAC_LEN      = MAC_BYTES_DEF;
	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_BYTES = 900;
	localparam logic [32:0] LEN_CAP = (33'd1 << LENGTH_COUNT_BITS_DEF) - 33'd1;

	typedef enum logic [1:0] {P_HEADER, P_PAYLOAD, P_TRAILER, P_MAC} parse_phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		status_t     status;
		logic [15:0] msg_type;
		logic [15:0] version;
		logic [31:0] flag_bits;
		logic [23:0] frame_length;
		logic        mac_present;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [31:0] cfg_wdata = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  stream_byte = 8'd0;
	logic        out_valid;
	logic        out_ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [3:0]  status;
	logic [15:0] msg_type;
	logic [15:0] version;
	logic [31:0] flag_bits;
	logic [23:0] frame_length;
	logic        mac_present;

	logic rx_want = 1'b0;
	logic rx_hold = 1'b0;
	bit   hold_pending = 1'b0;
	bit   tx_idle = 1'b1;
	bit   rx_idle = 1'b1;
	int   fail_count = 0;
	int   bytes_sent = 0;

	frame_result_t pending_results[$];

	// Register copies
	logic [31:0] cur_magic, cur_known, cur_smask;
	logic [15:0] cur_vmin, cur_vmax, cur_tmax;
	logic [23:0] cur_limit;
	logic        cur_req;

	// Parser state copies
	parse_phase_t p_phase;
	int unsigned  p_pos;
	logic [31:0]  p_crc, p_flags, p_len, p_rx_crc;
	logic [15:0]  p_ver, p_type;
	logic         p_magic_ok, p_halted;

	assign out_ready = rx_want & ~rx_hold;

	crc32c_frame_deframer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stream_byte(stream_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.status(status),
		.msg_type(msg_type),
		.version(version),
		.flag_bits(flag_bits),
		.frame_length(frame_length),
		.mac_present(mac_present)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance a reflected CRC32C by one byte
	function automatic logic [31:0] crc32c_next(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		return r;
	endfunction

	function automatic string result_text(frame_result_t r);
		return $sformatf(
			"kind %0d data %02h status %0d type %04h ver %04h flags %08h len %06h sig %0d",
			r.kind, r.data_byte, r.status, r.msg_type, r.version, r.flag_bits,
			r.frame_length, r.mac_present);
	endfunction

	function automatic void frame_restart();
		p_phase    = P_HEADER;
		p_pos      = 0;
		p_crc      = CRC_INIT;
		p_magic_ok = 1'b1;
		p_ver      = 16'h0;
		p_type     = 16'h0;
		p_flags    = 32'h0;
		p_len      = 32'h0;
		p_rx_crc   = 32'h0;
	endfunction

	function automatic void deframer_power_on();
		cur_magic = MAGIC_RST;
		cur_vmin  = VER_MIN_RST;
		cur_vmax  = VER_MAX_RST;
		cur_tmax  = TYPE_MAX_RST;
		cur_known = KNOWN_RST;
		cur_smask = SIGNED_RST;
		cur_limit = PAY_LIMIT_RST;
		cur_req   = 1'b0;
		frame_restart();
		p_halted = 1'b0;
	endfunction

	function automatic frame_result_t status_result(status_t st);
		frame_result_t r;
		r.kind         = KIND_STATUS;
		r.data_byte    = 8'h0;
		r.status       = st;
		r.msg_type     = p_type;
		r.version      = p_ver;
		r.flag_bits    = p_flags;
		r.frame_length = p_len[23:0];
		r.mac_present  = (p_flags & cur_smask) != 0;
		return r;
	endfunction

	// Run the header checks in priority order
	function automatic status_t header_verdict();
		logic sig;
		sig = (p_flags & cur_smask) != 0;
		if (!p_magic_ok) return ST_MAGIC;
		if (p_rx_crc != ~p_crc) return ST_HDR_CRC;
		if (p_ver < cur_vmin || p_ver > cur_vmax) return ST_VERSION;
		if (p_type == 16'h0 || p_type > cur_tmax) return ST_TYPE;
		if ((p_flags & ~cur_known) != 0) return ST_FLAGS;
		if (p_len > {8'h0, cur_limit} || {1'b0, p_len} > LEN_CAP) return ST_LENGTH;
		if (sig && !cur_req) return ST_SIGNED_NOKEY;
		if (!sig && cur_req) return ST_NEED_KEY;
		return ST_OK;
	endfunction

	// Close a frame on its payload CRC; halt on mismatch
	function automatic void frame_finish();
		status_t st;
		st = (p_rx_crc == ~p_crc) ? ST_OK : ST_PAYLOAD_CRC;
		pending_results.push_back(status_result(st));
		if (st == ST_OK)
			frame_restart();
		else
			p_halted = 1'b1;
	endfunction

	// Predict the results of one accepted stream byte
	function automatic void deframe_byte(logic [7:0] b);
		status_t       st;
		frame_result_t r;
		if (p_halted) return;
		case (p_phase)
		P_HEADER: begin
			if (p_pos < HDR_CRC_BYTES) p_crc = crc32c_next(p_crc, b);
			if (p_pos < 4) begin
				if (b != cur_magic[8 * (3 - p_pos) +: 8]) p_magic_ok = 1'b0;
			end else if (p_pos < 6) begin
				p_ver = {p_ver[7:0], b};
			end else if (p_pos < 8) begin
				p_type = {p_type[7:0], b};
			end else if (p_pos < 12) begin
				p_flags = {p_flags[23:0], b};
			end else if (p_pos < 16) begin
				p_len = {p_len[23:0], b};
			end else begin
				p_rx_crc = {p_rx_crc[23:0], b};
			end
			p_pos++;
			if (p_pos == HDR_BYTES) begin
				st = header_verdict();
				if (st != ST_OK) begin
					pending_results.push_back(status_result(st));
					p_halted = 1'b1;
				end else begin
					p_crc    = CRC_INIT;
					p_rx_crc = 32'h0;
					p_pos    = 0;
					p_phase  = (p_len == 0) ? P_TRAILER : P_PAYLOAD;
				end
			end
		end
		P_PAYLOAD: begin
			p_crc = crc32c_next(p_crc, b);
			p_pos++;
			if (p_pos >= p_len) begin
				p_pos   = 0;
				p_phase = P_TRAILER;
			end
			r           = '0;
			r.kind      = KIND_DATA;
			r.data_byte = b;
			r.status    = ST_OK;
			pending_results.push_back(r);
		end
		P_TRAILER: begin
			p_rx_crc = {p_rx_crc[23:0], b};
			p_pos++;
			if (p_pos == TRAILER_BYTES) begin
				p_pos = 0;
				if ((p_flags & cur_smask) != 0 && MAC_LEN > 0)
					p_phase = P_MAC;
				else
					frame_finish();
			end
		end
		default: begin
			// skip the unverified MAC
			p_pos++;
			if (p_pos == MAC_LEN) begin
				p_pos = 0;
				frame_finish();
			end
		end
		endcase
	endfunction

	// Offer one request and wait until it is taken
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		deframe_byte(b);
		bytes_sent++;
	endtask

	// Drop valid, wait for every expected result, then let the pipe settle
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
		REG_MAGIC:       cur_magic = val;
		REG_VER_MIN:     cur_vmin  = val[15:0];
		REG_VER_MAX:     cur_vmax  = val[15:0];
		REG_TYPE_MAX:    cur_tmax  = val[15:0];
		REG_KNOWN_MASK:  cur_known = val;
		REG_SIGNED_MASK: cur_smask = val;
		REG_PAY_LIMIT:   cur_limit = val[23:0];
		default:         cur_req   = val[0];
		endcase
	endtask

	task automatic set_config(logic [31:0] magic, logic [15:0] vmin, logic [15:0] vmax,
			logic [15:0] tmax, logic [31:0] known, logic [31:0] smask,
			logic [23:0] limit, logic req);
		drain_results();
		cfg_write(REG_MAGIC, magic);
		cfg_write(REG_VER_MIN, {16'h0, vmin});
		cfg_write(REG_VER_MAX, {16'h0, vmax});
		cfg_write(REG_TYPE_MAX, {16'h0, tmax});
		cfg_write(REG_KNOWN_MASK, known);
		cfg_write(REG_SIGNED_MASK, smask);
		cfg_write(REG_PAY_LIMIT, {8'h0, limit});
		cfg_write(REG_SIGN_REQ, {31'h0, req});
	endtask

	// Send a header, optionally with a wrong magic bit or a wrong CRC bit
	task automatic send_header(logic [15:0] ver, logic [15:0] typ, logic [31:0] flags,
			logic [31:0] len, bit bad_magic, bit bad_crc);
		logic [31:0]  m, c;
		logic [127:0] fields;
		int           pick;
		m = cur_magic;
		if (bad_magic) begin
			pick = $urandom_range(0, 31);
			m[pick] = ~m[pick];
		end
		fields = {m, ver, typ, flags, len};
		c = CRC_INIT;
		for (int i = 0; i < HDR_CRC_BYTES; i++) begin
			c = crc32c_next(c, fields[127 - 8 * i -: 8]);
			send_byte(fields[127 - 8 * i -: 8]);
		end
		c = ~c;
		if (bad_crc) c = c ^ (32'h1 << $urandom_range(0, 31));
		for (int i = 3; i >= 0; i--) send_byte(c[8 * i +: 8]);
	endtask

	// Send payload (constant fill, or random when fill is negative), trailer and MAC
	task automatic send_body(int len, bit with_mac, bit bad_crc, int fill);
		logic [31:0] c;
		logic [7:0]  b;
		c = CRC_INIT;
		for (int i = 0; i < len; i++) begin
			b = (fill < 0) ? 8'($urandom) : 8'(fill);
			c = crc32c_next(c, b);
			send_byte(b);
		end
		c = ~c;
		if (bad_crc) c = c ^ (32'h1 << $urandom_range(0, 31));
		for (int i = 3; i >= 0; i--) send_byte(c[8 * i +: 8]);
		if (with_mac) repeat (MAC_LEN) send_byte(8'($urandom));
	endtask

	task automatic send_good_frame(logic [15:0] ver, logic [15:0] typ, logic [31:0] flags,
			int len, int fill);
		send_header(ver, typ, flags, len, 1'b0, 1'b0);
		send_body(len, (flags & cur_smask) != 0, 1'b0, fill);
	endtask

	// Send a frame that passes every check under the current settings
	task automatic send_random_frame(int max_len);
		logic [15:0] ver, typ;
		logic [31:0] flags, sign_bits, allowed;
		int          cap;
		ver   = 16'($urandom_range(cur_vmin, cur_vmax));
		typ   = 16'($urandom_range(1, cur_tmax));
		flags = $urandom & cur_known & ~cur_smask;
		if (cur_req) begin
			allowed   = cur_known & cur_smask;
			sign_bits = $urandom & allowed;
			if (sign_bits == 0) sign_bits = allowed & (~allowed + 32'h1);
			flags = flags | sign_bits;
		end
		cap = (cur_limit < max_len) ? int'(cur_limit) : max_len;
		send_good_frame(ver, typ, flags, $urandom_range(0, cap), -1);
	endtask

	task automatic randomize_settings();
		logic [15:0] v0, v1, tm;
		logic [31:0] known, smask;
		logic [23:0] limit;
		logic        req;
		v0 = 16'($urandom);
		v1 = 16'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			v0 = 16'h0000;
			v1 = 16'hFFFF;
		end
		if (v0 > v1) {v0, v1} = {v1, v0};
		tm = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 30))
			: 16'($urandom_range(1, 65535));
		known = $urandom;
		case ($urandom_range(0, 3))
		0:       smask = 32'h0;
		1:       smask = 32'h1 << $urandom_range(0, 31);
		default: smask = $urandom & $urandom;
		endcase
		case ($urandom_range(0, 3))
		0:       limit = 24'h0;
		1:       limit = 24'hFF_FFFF;
		default: limit = 24'($urandom_range(1, 40));
		endcase
		req = ($urandom_range(0, 1) == 1) && ((known & smask) != 0);
		set_config($urandom, v0, v1, tm, known, smask, limit, req);
	endtask

	// Reset settings: empty payload, extreme payload bytes, type range ends
	task automatic test_default_frames();
		send_good_frame(16'd1, 16'd1, 32'h0, 0, -1);
		send_good_frame(16'd1, TYPE_MAX_RST, 32'h0, 1, 8'h00);
		send_good_frame(16'd1, 16'd13, 32'h0, 1, 8'hFF);
		drain_results();
	endtask

	// Extreme register settings, mostly all-zero or all-one, with and without signing
	task automatic test_register_extremes();
		set_config(32'h0, 16'h0, 16'h0, 16'd1, 32'h0, 32'h0, 24'h0, 1'b0);
		send_good_frame(16'h0, 16'd1, 32'h0, 0, -1);
		set_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
			32'h8000_0000, 24'hFF_FFFF, 1'b1);
		send_good_frame(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 3, -1);
		drain_results();
	endtask

	// Hold off the receiver during a long payload so the input backs up
	task automatic test_output_stall();
		set_config(MAGIC_RST, VER_MIN_RST, VER_MAX_RST, TYPE_MAX_RST, KNOWN_RST,
			SIGNED_RST, PAY_LIMIT_RST, 1'b0);
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		send_header(16'd1, 16'd7, 32'h0, 240, 1'b0, 1'b0);
		hold_pending = 1'b1;
		send_body(240, 1'b0, 1'b0, -1);
		drain_results();
	endtask

	// Well-formed frames with random content under changing settings
	task automatic test_random_frames();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			randomize_settings();
			repeat ($urandom_range(3, 8)) begin
				tx_idle = $urandom_range(0, 3) != 0;
				rx_idle = $urandom_range(0, 3) != 0;
				send_random_frame(($urandom_range(0, 9) == 0) ? 200 : 12);
			end
		end
		drain_results();
	endtask

	// One error frame of a random kind, then bytes that must be dropped
	task automatic test_error_halt();
		status_t     err;
		logic [15:0] ver, typ;
		logic [31:0] flags, len;
		int          pay;
		err = status_t'($urandom_range(1, 9));
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		set_config(MAGIC_RST, VER_MIN_RST, VER_MAX_RST, TYPE_MAX_RST, KNOWN_RST,
			SIGNED_RST, PAY_LIMIT_RST, err == ST_NEED_KEY);
		ver   = 16'd1;
		typ   = 16'($urandom_range(1, 26));
		flags = 32'h0;
		len   = 32'($urandom_range(0, 8));
		case (err)
		ST_VERSION:      ver = ($urandom_range(0, 1) == 1) ? 16'h0 : 16'($urandom_range(2, 65535));
		ST_TYPE:         typ = ($urandom_range(0, 1) == 1) ? 16'h0 : 16'($urandom_range(27, 65535));
		ST_FLAGS:        flags = $urandom | 32'h2;
		ST_LENGTH: begin
			if ($urandom_range(0, 1) == 1)
				len = {8'h0, PAY_LIMIT_RST} + 32'd1 + 32'($urandom_range(0, 1000));
			else
				len = $urandom | 32'h0100_0000;
		end
		ST_SIGNED_NOKEY: flags = 32'h1;
		default: ;
		endcase
		send_header(ver, typ, flags, len, err == ST_MAGIC, err == ST_HDR_CRC);
		if (err == ST_PAYLOAD_CRC) begin
			pay = int'(len);
			send_body(pay, 1'b0, 1'b1, -1);
		end
		repeat (20) send_byte(8'($urandom));
		drain_results();
	endtask

	// Take results with random stalls and check them in order
	initial begin : result_check
		frame_result_t got, want;
		int            stall;
		forever begin
			stall = rx_idle ? $urandom_range(0, 8) : 0;
			@(negedge clk);
			if (stall > 0) begin
				rx_want <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rx_want <= 1'b1;
			@(posedge clk);
			while (!(out_valid === 1'b1 && out_ready === 1'b1)) @(posedge clk);
			got.kind         = kind;
			got.data_byte    = data_byte;
			got.status       = status_t'(status);
			got.msg_type     = msg_type;
			got.version      = version;
			got.flag_bits    = flag_bits;
			got.frame_length = frame_length;
			got.mac_present  = mac_present;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) $display("unexpected result: %s", result_text(got));
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.data_byte !== want.data_byte
						|| got.status !== want.status || got.msg_type !== want.msg_type
						|| got.version !== want.version || got.flag_bits !== want.flag_bits
						|| got.frame_length !== want.frame_length
						|| got.mac_present !== want.mac_present) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch expected: %s", result_text(want));
						$display("         actual:   %s", result_text(got));
					end
				end
			end
		end
	end

	// Long receiver hold-off, counted here in cycles
	initial begin : output_hold
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold <= 1'b0;
			end
		end
	end

	// End the run if neither channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_ready === 1'b1)
					|| (out_valid === 1'b1 && out_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("crc32c_frame_deframer_tb: done, errors");
		$finish;
	end

	initial begin
		deframer_power_on();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_default_frames();
		test_register_extremes();
		test_output_stall();
		test_random_frames();
		test_error_halt();
		fail_count += pending_results.size();
		if (fail_count == 0)
			$display("crc32c_frame_deframer_tb: done, clean");
		else
			$display("crc32c_frame_deframer_tb: done, errors");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/crcfd_pkg.sv
hw/rtl/crc32c_frame_deframer.sv
test/crc32c_frame_deframer_tb.sv
